### rtl/core/tspsr_pkg.sv
// Shared constants, codes, types and helpers of the PID/SID remapper.
package tspsr_pkg;

    localparam int REAL_PID_COUNT = 8192;
    localparam int PID_W          = $clog2(REAL_PID_COUNT);
    localparam int UNIQ_SLOTS     = 256;
    localparam int SLOT_W         = 8;
    localparam int SID_DEPTH      = 64;
    localparam int SID_IDX_W      = $clog2(SID_DEPTH);
    localparam int SID_CNT_W      = $clog2(SID_DEPTH + 1);
    localparam int SID_W          = 16;
    localparam int NUM_W          = 5;
    localparam int VALUE_W        = 16;
    localparam int STATUS_W       = 2;
    localparam int CMD_W          = 2;

    localparam logic [VALUE_W-1:0] UNMAPPED_VALUE = 16'hFFFF;

    localparam logic [CMD_W-1:0] CMD_REAL_TO_UNIQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNIQ_TO_REAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP_SID      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SID_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_FWD_CHK,
        S_FWD_CMP,
        S_SCAN,
        S_REV_OUT,
        S_SID_CMP,
        S_SID_END
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [PID_W-1:0]  waddr;
        logic [SLOT_W-1:0] wdata;
        logic [PID_W-1:0]  raddr;
    } fwd_req_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [PID_W-1:0]  wdata;
        logic [SLOT_W-1:0] raddr;
    } rev_req_t;

    typedef struct packed {
        logic                 we;
        logic [SID_IDX_W-1:0] waddr;
        logic [SID_W-1:0]     wdata;
        logic [SID_IDX_W-1:0] raddr;
    } sid_req_t;

    function automatic logic [VALUE_W-1:0] make_id(input logic [NUM_W-1:0]  num,
                                                   input logic [SLOT_W-1:0] low);
        make_id = VALUE_W'({num, low});
    endfunction

endpackage

### rtl/core/tspsr_ram.sv
// Simple dual-port RAM with registered read data.
module tspsr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/tspsr_seq.sv
// Sequencer and shared compare unit: lookups, slot search, SID scan, clear.
module tspsr_seq import tspsr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CMD_W-1:0]    command,
    input  logic [PID_W-1:0]    real_pid,
    input  logic [PID_W-1:0]    uniq_pid,
    input  logic [SID_W-1:0]    real_sid,
    input  logic [NUM_W-1:0]    mapper_number,
    output logic                busy,
    output logic                done,
    output logic [VALUE_W-1:0]  mapped_value,
    output logic [STATUS_W-1:0] status,
    output fwd_req_t            fwd_req,
    input  logic [SLOT_W-1:0]   fwd_rdata,
    output rev_req_t            rev_req,
    input  logic [PID_W-1:0]    rev_rdata,
    output sid_req_t            sid_req,
    input  logic [SID_W-1:0]    sid_rdata
);

    seq_state_t state_reg, state_next;

    logic [PID_W-1:0]      wipe_reg, wipe_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [UNIQ_SLOTS-1:0] rev_valid_reg, rev_valid_next;
    logic [SID_CNT_W-1:0]  sid_count_reg, sid_count_next;
    logic                  done_reg, done_next;

    logic [PID_W-1:0]      pid_reg, pid_next;
    logic [SID_W-1:0]      sid_reg, sid_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  hit_vld_reg, hit_vld_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [SID_IDX_W-1:0]  k_reg, k_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  accept;
    logic [SLOT_W-1:0]     vld_idx;
    logic                  vld_rd;
    logic [VALUE_W-1:0]    cmp_a;
    logic [VALUE_W-1:0]    cmp_b;
    logic                  cmp_eq;
    logic                  fwd_hit;
    logic                  scan_last;
    logic                  sid_last;
    logic                  sid_full;
    logic [SLOT_W-1:0]     cur_inc;

    assign accept = start && (state_reg == S_IDLE);

    // One read port on the slot valid bits, steered by state.
    always_comb
    begin
        case (state_reg)
            S_IDLE:    vld_idx = uniq_pid[SLOT_W-1:0];
            S_FWD_CHK: vld_idx = fwd_rdata;
            default:   vld_idx = cur_reg;
        endcase
    end
    assign vld_rd = rev_valid_reg[vld_idx];

    // Shared equality unit: forward hit check and SID scan.
    always_comb
    begin
        case (state_reg)
            S_SID_CMP:
            begin
                cmp_a = VALUE_W'(sid_rdata);
                cmp_b = VALUE_W'(sid_reg);
            end
            default:
            begin
                cmp_a = VALUE_W'(rev_rdata);
                cmp_b = VALUE_W'(pid_reg);
            end
        endcase
    end
    assign cmp_eq = (cmp_a == cmp_b);

    // A forward entry counts only if its slot is live and points back to this PID.
    assign fwd_hit   = hit_vld_reg && cmp_eq;
    assign scan_last = (cnt_reg == SLOT_W'(UNIQ_SLOTS - 1));
    assign sid_last  = ((SID_CNT_W'(k_reg) + SID_CNT_W'(1)) == sid_count_reg);
    assign sid_full  = (sid_count_reg == SID_CNT_W'(SID_DEPTH));
    assign cur_inc   = (cur_reg == SLOT_W'(UNIQ_SLOTS - 1)) ? '0 : cur_reg + SLOT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_WIPE:
            begin
                if (wipe_reg == PID_W'(REAL_PID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_REAL_TO_UNIQ: state_next = S_FWD_CHK;
                        CMD_UNIQ_TO_REAL: state_next = S_REV_OUT;
                        CMD_MAP_SID:
                        begin
                            state_next = (sid_count_reg == '0) ? S_SID_END : S_SID_CMP;
                        end
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_FWD_CHK: state_next = S_FWD_CMP;
            S_FWD_CMP: state_next = fwd_hit ? S_IDLE : S_SCAN;
            S_SCAN:
            begin
                if (!vld_rd || scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REV_OUT: state_next = S_IDLE;
            S_SID_CMP:
            begin
                if (cmp_eq)
                begin
                    state_next = S_IDLE;
                end
                else if (sid_last)
                begin
                    state_next = S_SID_END;
                end
            end
            S_SID_END: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        wipe_next      = wipe_reg;
        next_slot_next = next_slot_reg;
        rev_valid_next = rev_valid_reg;
        sid_count_next = sid_count_reg;
        done_next      = 1'b0;
        pid_next       = pid_reg;
        sid_next       = sid_reg;
        slot_next      = slot_reg;
        hit_vld_next   = hit_vld_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        value_next     = value_reg;
        status_next    = status_reg;

        fwd_req.we     = 1'b0;
        fwd_req.waddr  = pid_reg;
        fwd_req.wdata  = cur_reg;
        fwd_req.raddr  = real_pid;
        rev_req.we     = 1'b0;
        rev_req.waddr  = cur_reg;
        rev_req.wdata  = pid_reg;
        rev_req.raddr  = uniq_pid[SLOT_W-1:0];
        sid_req.we     = 1'b0;
        sid_req.waddr  = sid_count_reg[SID_IDX_W-1:0];
        sid_req.wdata  = sid_reg;
        sid_req.raddr  = '0;

        case (state_reg)
            S_WIPE:
            begin
                fwd_req.we    = 1'b1;
                fwd_req.waddr = wipe_reg;
                fwd_req.wdata = '0;
                wipe_next     = wipe_reg + PID_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    pid_next     = real_pid;
                    sid_next     = real_sid;
                    hit_vld_next = vld_rd;
                    k_next       = '0;
                    if (command == CMD_CLEAR)
                    begin
                        rev_valid_next = '0;
                        sid_count_next = '0;
                        done_next      = 1'b1;
                        value_next     = '0;
                        status_next    = STAT_OK;
                    end
                end
            end
            S_FWD_CHK:
            begin
                rev_req.raddr = fwd_rdata;
                slot_next     = fwd_rdata;
                hit_vld_next  = vld_rd;
            end
            S_FWD_CMP:
            begin
                if (fwd_hit)
                begin
                    done_next   = 1'b1;
                    value_next  = make_id(mapper_number, slot_reg);
                    status_next = STAT_OK;
                end
                else
                begin
                    cur_next = next_slot_reg;
                    cnt_next = '0;
                end
            end
            S_SCAN:
            begin
                if (!vld_rd)
                begin
                    // Claim the free slot in both directions.
                    rev_req.we              = 1'b1;
                    fwd_req.we              = 1'b1;
                    rev_valid_next[cur_reg] = 1'b1;
                    next_slot_next          = cur_inc;
                    done_next               = 1'b1;
                    value_next              = make_id(mapper_number, cur_reg);
                    status_next             = STAT_OK;
                end
                else if (scan_last)
                begin
                    done_next   = 1'b1;
                    value_next  = '0;
                    status_next = STAT_NO_SLOT;
                end
                else
                begin
                    cur_next = cur_inc;
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end
            S_REV_OUT:
            begin
                done_next   = 1'b1;
                value_next  = hit_vld_reg ? VALUE_W'(rev_rdata) : UNMAPPED_VALUE;
                status_next = STAT_OK;
            end
            S_SID_CMP:
            begin
                // Read the next entry while comparing this one.
                sid_req.raddr = k_reg + SID_IDX_W'(1);
                if (cmp_eq)
                begin
                    done_next   = 1'b1;
                    value_next  = make_id(mapper_number, SLOT_W'(k_reg));
                    status_next = STAT_OK;
                end
                else if (!sid_last)
                begin
                    k_next = k_reg + SID_IDX_W'(1);
                end
            end
            S_SID_END:
            begin
                done_next = 1'b1;
                if (sid_full)
                begin
                    value_next  = '0;
                    status_next = STAT_SID_FULL;
                end
                else
                begin
                    sid_req.we     = 1'b1;
                    sid_count_next = sid_count_reg + SID_CNT_W'(1);
                    value_next     = make_id(mapper_number, SLOT_W'(sid_count_reg));
                    status_next    = STAT_OK;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            wipe_reg      <= '0;
            next_slot_reg <= '0;
            rev_valid_reg <= '0;
            sid_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wipe_reg      <= wipe_next;
            next_slot_reg <= next_slot_next;
            rev_valid_reg <= rev_valid_next;
            sid_count_reg <= sid_count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg     <= pid_next;
        sid_reg     <= sid_next;
        slot_reg    <= slot_next;
        hit_vld_reg <= hit_vld_next;
        cur_reg     <= cur_next;
        cnt_reg     <= cnt_next;
        k_reg       <= k_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign mapped_value = value_reg;
    assign status       = status_reg;

endmodule

### rtl/core/ts_pid_sid_remapper_top.sv
// Top level of the transport-stream PID/SID remapper.
//
// Command channel: an item transfers at a rising edge with start high and busy
// low; command selects real-to-unique PID, unique-to-real PID, map SID or clear.
// One result per item: mapped_value and status are shown for one cycle with
// done high. The receiver cannot stall; each result is taken as it appears.
// Steps per command: clear completes in idle; reverse lookup reads the slot's
//   reverse entry and valid bit; an already mapped PID reads the forward then
//   the reverse map and checks the slot; a new PID then probes n slots (1 to
//   256), a slot valid bit tested per cycle starting at the next-slot pointer;
//   SID compares k stored SIDs (one table read per cycle), then appends the
//   SID or reports the table full when none matches.
// busy stays high for every item but clear, so items run one at a time.
// After reset all 8192 forward map entries are swept, one entry per cycle,
// with busy high. Reset empties all maps, zeroes the next-slot pointer
// and sets mapper_number to 1. The configuration channel always takes a
// transfer (cfg_ready is high); write it only while the block is idle.
module ts_pid_sid_remapper_top import tspsr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [PID_W-1:0]    real_pid,
    input  logic [PID_W-1:0]    uniq_pid,
    input  logic [SID_W-1:0]    real_sid,
    output logic                done,
    output logic [VALUE_W-1:0]  mapped_value,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NUM_W-1:0]    cfg_data
);

    logic [NUM_W-1:0]  mapper_number_reg, mapper_number_next;

    fwd_req_t          fwd_req;
    rev_req_t          rev_req;
    sid_req_t          sid_req;
    logic [SLOT_W-1:0] fwd_rdata;
    logic [PID_W-1:0]  rev_rdata;
    logic [SID_W-1:0]  sid_rdata;

    assign cfg_ready          = 1'b1;
    assign mapper_number_next = (cfg_valid && cfg_ready) ? cfg_data : mapper_number_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_number_reg <= NUM_W'(1);
        end
        else
        begin
            mapper_number_reg <= mapper_number_next;
        end
    end

    tspsr_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .command       (command),
        .real_pid      (real_pid),
        .uniq_pid      (uniq_pid),
        .real_sid      (real_sid),
        .mapper_number (mapper_number_reg),
        .busy          (busy),
        .done          (done),
        .mapped_value  (mapped_value),
        .status        (status),
        .fwd_req       (fwd_req),
        .fwd_rdata     (fwd_rdata),
        .rev_req       (rev_req),
        .rev_rdata     (rev_rdata),
        .sid_req       (sid_req),
        .sid_rdata     (sid_rdata)
    );

    // Forward map: real PID to slot.
    tspsr_ram #(
        .DEPTH (REAL_PID_COUNT),
        .WIDTH (SLOT_W)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_req.we),
        .waddr (fwd_req.waddr),
        .wdata (fwd_req.wdata),
        .raddr (fwd_req.raddr),
        .rdata (fwd_rdata)
    );

    // Reverse map: slot to real PID.
    tspsr_ram #(
        .DEPTH (UNIQ_SLOTS),
        .WIDTH (PID_W)
    ) u_rev_ram (
        .clk   (clk),
        .we    (rev_req.we),
        .waddr (rev_req.waddr),
        .wdata (rev_req.wdata),
        .raddr (rev_req.raddr),
        .rdata (rev_rdata)
    );

    // Service id table in first-seen order.
    tspsr_ram #(
        .DEPTH (SID_DEPTH),
        .WIDTH (SID_W)
    ) u_sid_ram (
        .clk   (clk),
        .we    (sid_req.we),
        .waddr (sid_req.waddr),
        .wdata (sid_req.wdata),
        .raddr (sid_req.raddr),
        .rdata (sid_rdata)
    );

endmodule
